// ===== hdl/abb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and register indexes for the alpha blend blitter.
package abb_pkg;

  // Defaults for the top level parameters
  localparam int FB_WORDS_DEF = 262144;
  localparam int MAX_DIM_DEF  = 512;

  // Fixed field widths
  localparam int DIM_W    = 10;  // width/height registers
  localparam int POS_W    = 11;  // signed destination origin, also cfg data width
  localparam int SUM_W    = POS_W + 1;  // column/row after adding the origin
  localparam int PIX_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ADDR_W_DEF = $clog2(FB_WORDS_DEF);

  // Queue between front and back
  localparam int QDEPTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_W    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_H    = 3'd5;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_FB_WIDTH  = 10'd512;
  localparam logic [DIM_W-1:0] RST_FB_HEIGHT = 10'd512;
  localparam logic [POS_W-1:0] RST_DEST_X    = 11'd0;
  localparam logic [POS_W-1:0] RST_DEST_Y    = 11'd0;
  localparam logic [DIM_W-1:0] RST_DEST_W    = 10'd1;
  localparam logic [DIM_W-1:0] RST_DEST_H    = 10'd1;

endpackage

// ===== hdl/abb_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces: source pixel input, result output, register writes.

interface abb_in_if;
  logic                      valid;
  logic                      ready;
  logic [abb_pkg::PIX_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

interface abb_out_if #(
  parameter int ADDR_W = abb_pkg::ADDR_W_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      write_enable;
  logic [ADDR_W-1:0]         fb_address;
  logic [abb_pkg::PIX_W-1:0] out_pixel;
  logic                      last;

  modport source (output valid, output write_enable, output fb_address,
                  output out_pixel, output last, input ready);
  modport sink   (input valid, input write_enable, input fb_address,
                  input out_pixel, input last, output ready);
endinterface

interface abb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [abb_pkg::CFG_IDX_W-1:0] index;
  logic [abb_pkg::POS_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/abb_front.sv =====
`timescale 1ns / 1ps
// Front end: config registers, window walk, clipping and address generation.
module abb_front #(
  parameter int FB_WORDS = abb_pkg::FB_WORDS_DEF,
  parameter int MAX_DIM  = abb_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr_busy,
  abb_in_if.sink                          in_px,
  abb_cfg_if.sink                         cfg_wr,
  // job word toward the queue
  output logic                            q_valid,
  input  logic                            q_ready,
  output logic                            job_we,
  output logic [$clog2(FB_WORDS)-1:0]     job_addr,
  output logic [abb_pkg::PIX_W-1:0]       job_src,
  output logic                            job_last
);

  localparam int AW   = $clog2(FB_WORDS);
  localparam int DW   = $clog2(MAX_DIM + 1);  // clamped dimension
  localparam int CW   = $clog2(MAX_DIM);      // window counters
  localparam int PW   = 2 * DW + 1;           // row * width + col
  localparam int CMPW = (PW > AW + 1) ? PW : AW + 1;
  localparam int SW   = abb_pkg::SUM_W;

  // config registers
  logic [abb_pkg::DIM_W-1:0] fbw_r, fbh_r, dw_r, dh_r;
  logic [abb_pkg::POS_W-1:0] dx_r, dy_r;

  // window counters
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [CW-1:0] row_cnt_r, row_cnt_nxt;

  logic          accept;
  logic [DW-1:0] fbw, fbh, win_w, win_h, x0;
  logic [abb_pkg::POS_W-2:0] y0;
  logic [SW-1:0] col, row;
  logic [2*DW-1:0] prod;
  logic [PW-1:0] addr_full;
  logic          in_fb, row_end, win_end;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DW-1:0] dim_lim(input logic [abb_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  assign cfg_wr.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbw_r <= abb_pkg::RST_FB_WIDTH;
      fbh_r <= abb_pkg::RST_FB_HEIGHT;
      dx_r  <= abb_pkg::RST_DEST_X;
      dy_r  <= abb_pkg::RST_DEST_Y;
      dw_r  <= abb_pkg::RST_DEST_W;
      dh_r  <= abb_pkg::RST_DEST_H;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        abb_pkg::CFG_FB_WIDTH:  fbw_r <= cfg_wr.data[abb_pkg::DIM_W-1:0];
        abb_pkg::CFG_FB_HEIGHT: fbh_r <= cfg_wr.data[abb_pkg::DIM_W-1:0];
        abb_pkg::CFG_DEST_X:    dx_r  <= cfg_wr.data;
        abb_pkg::CFG_DEST_Y:    dy_r  <= cfg_wr.data;
        abb_pkg::CFG_DEST_W:    dw_r  <= cfg_wr.data[abb_pkg::DIM_W-1:0];
        abb_pkg::CFG_DEST_H:    dh_r  <= cfg_wr.data[abb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    fbw   = dim_lim(fbw_r);
    fbh   = dim_lim(fbh_r);
    win_w = dim_lim(dw_r);
    win_h = dim_lim(dh_r);
    // origin x clamped to [0, width-1]
    if (dx_r[abb_pkg::POS_W-1]) begin
      x0 = '0;
    end else if (int'(dx_r[abb_pkg::POS_W-2:0]) > int'(fbw) - 1) begin
      x0 = fbw - DW'(1);
    end else begin
      x0 = DW'(dx_r[abb_pkg::POS_W-2:0]);
    end
    // origin y clamped at zero
    y0 = dy_r[abb_pkg::POS_W-1] ? '0 : dy_r[abb_pkg::POS_W-2:0];
  end

  // position, clipping and word address
  always_comb begin
    col       = SW'(x0) + SW'(col_cnt_r);
    row       = SW'(y0) + SW'(row_cnt_r);
    in_fb     = (col < SW'(fbw)) && (row < SW'(fbh));
    prod      = (2*DW)'(row[DW-1:0]) * (2*DW)'(fbw);
    addr_full = PW'(prod) + PW'(col[DW-1:0]);
    job_we    = in_fb && (CMPW'(addr_full) < CMPW'(FB_WORDS));
    job_addr  = job_we ? AW'(addr_full) : '0;
    job_src   = in_px.src_pixel;
    row_end   = DW'(col_cnt_r) >= win_w - DW'(1);
    win_end   = DW'(row_cnt_r) >= win_h - DW'(1);
    job_last  = row_end && win_end;
  end

  assign in_px.ready = q_ready && !clr_busy;
  assign q_valid     = in_px.valid && !clr_busy;
  assign accept      = in_px.valid && in_px.ready;

  // window walk
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (row_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = win_end ? '0 : row_cnt_r + CW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

// ===== hdl/abb_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the front end and the blend back end.
module abb_queue #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = abb_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // pointers agree with the occupancy count
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(DEPTH)) || (PTR_W'(wptr_r - rptr_r) == count_r[PTR_W-1:0]))
    else $error("queue pointers disagree with count");

  // a push into an empty queue shows up at the head next cycle
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    (push && count_r == '0) |=> (pop_valid && pop_data == $past(push_data)))
    else $error("queue head lost pushed word");

endmodule

// ===== hdl/abb_back.sv =====
`timescale 1ns / 1ps
// Back end: framebuffer memory, clearing pass, read-blend-write and output register.
module abb_back #(
  parameter int FB_WORDS = abb_pkg::FB_WORDS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  logic [$clog2(FB_WORDS)+abb_pkg::PIX_W+1:0] q_data,
  output logic                                   clr_busy,
  abb_out_if.source                              out_px
);

  localparam int AW = $clog2(FB_WORDS);
  localparam int PX = abb_pkg::PIX_W;

  logic [PX-1:0] frame_mem [FB_WORDS];

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // blend stage
  logic          b_v_r, b_we_r, b_last_r;
  logic [AW-1:0] b_addr_r;
  logic [PX-1:0] b_src_r, rdata_r;

  // last word written, for read-after-write bypass
  logic          fwd_v_r;
  logic [AW-1:0] fwd_addr_r;
  logic [PX-1:0] fwd_data_r;

  // output register
  logic          o_v_r, o_we_r, o_last_r;
  logic [AW-1:0] o_addr_r;
  logic [PX-1:0] o_pix_r;

  logic          q_we, q_last, q_pop, b_adv, mem_we;
  logic [AW-1:0] q_addr, mem_wa;
  logic [PX-1:0] q_src, dst, blend_pix, mem_wd;

  // (a*s + (255-a)*d) / 255, the divide done as a shift-add that is exact below 2^16
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] s,
                                        input logic [7:0] d);
    logic [15:0] x;
    logic [16:0] t;
    x = 16'(a) * 16'(s) + 16'(8'd255 - a) * 16'(d);
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

  assign {q_we, q_addr, q_src, q_last} = q_data;

  assign clr_busy = clr_busy_r;
  assign b_adv    = b_v_r && (!o_v_r || out_px.ready);
  assign q_ready  = !clr_busy_r && (!b_v_r || b_adv);
  assign q_pop    = q_valid && q_ready;

  // destination pixel with bypass of the word written last
  assign dst = (fwd_v_r && fwd_addr_r == b_addr_r) ? fwd_data_r : rdata_r;

  // per channel blend, alpha from source
  always_comb begin
    blend_pix[PX-1:24] = b_src_r[PX-1:24];
    for (int c = 0; c < 3; c++) begin
      blend_pix[8*c +: 8] = blend8(b_src_r[PX-1:24], b_src_r[8*c +: 8], dst[8*c +: 8]);
    end
  end

  // memory write port: clearing sweep or blended word
  always_comb begin
    mem_we = clr_busy_r || (b_adv && b_we_r);
    mem_wa = clr_busy_r ? clr_addr_r : b_addr_r;
    mem_wd = clr_busy_r ? '0 : blend_pix;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rdata_r <= frame_mem[q_addr];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(FB_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      o_v_r   <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b_v_r <= 1'b1;
      end else if (b_adv) begin
        b_v_r <= 1'b0;
      end
      if (b_adv) begin
        o_v_r <= 1'b1;
      end else if (out_px.ready) begin
        o_v_r <= 1'b0;
      end
      if (clr_busy_r) begin
        fwd_v_r <= 1'b0;
      end else if (b_adv && b_we_r) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_we_r   <= q_we;
      b_addr_r <= q_addr;
      b_src_r  <= q_src;
      b_last_r <= q_last;
    end
    if (b_adv && b_we_r) begin
      fwd_addr_r <= b_addr_r;
      fwd_data_r <= blend_pix;
    end
    if (b_adv) begin
      o_we_r   <= b_we_r;
      o_addr_r <= b_addr_r;
      o_pix_r  <= b_we_r ? blend_pix : '0;
      o_last_r <= b_last_r;
    end
  end

  assign out_px.valid        = o_v_r;
  assign out_px.write_enable = o_we_r;
  assign out_px.fb_address   = o_addr_r;
  assign out_px.out_pixel    = o_pix_r;
  assign out_px.last         = o_last_r;

  // nothing moves through the pipe while the store is being cleared
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!b_v_r && !o_v_r && !q_pop))
    else $error("pipe active during clearing pass");

  // every blended write is captured for the bypass
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (b_adv && b_we_r && !clr_busy_r) |=>
      (fwd_v_r && fwd_addr_r == $past(b_addr_r) && fwd_data_r == $past(blend_pix)))
    else $error("bypass register missed a write");

endmodule

// ===== hdl/alpha_blend_blitter.sv =====
`timescale 1ns / 1ps
// Path: an accepted word is held in the queue, then the blend and output registers.
// Throughput: one pixel per cycle while out_px.ready is high; the read-blend-write loop
//   bypasses the last written word, so back-to-back hits on one address do not stall.
// Reset: rst_n clears control and loads register defaults, then the framebuffer is
//   swept to zero across all FB_WORDS words (262144 by default) with in_px.ready held low.
module alpha_blend_blitter #(
  parameter int FB_WORDS = abb_pkg::FB_WORDS_DEF,
  parameter int MAX_DIM  = abb_pkg::MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  abb_in_if.sink     in_px,
  abb_out_if.source  out_px,
  abb_cfg_if.sink    cfg_wr
);

  localparam int AW = $clog2(FB_WORDS);
  localparam int JW = AW + abb_pkg::PIX_W + 2;

  logic                      f_valid, f_ready, f_we, f_last;
  logic [AW-1:0]             f_addr;
  logic [abb_pkg::PIX_W-1:0] f_src;
  logic                      q_valid, q_ready, clr_busy;
  logic [JW-1:0]             q_data;

  abb_front #(
    .FB_WORDS (FB_WORDS),
    .MAX_DIM  (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .in_px    (in_px),
    .cfg_wr   (cfg_wr),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .job_we   (f_we),
    .job_addr (f_addr),
    .job_src  (f_src),
    .job_last (f_last)
  );

  abb_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_we, f_addr, f_src, f_last}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  abb_back #(
    .FB_WORDS (FB_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .clr_busy (clr_busy),
    .out_px   (out_px)
  );

endmodule

// ===== tb/sv/alpha_blend_blitter_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for alpha_blend_blitter: blend predictor, scoreboard, windows.
module alpha_blend_blitter_test;

  localparam int ADDR_W      = abb_pkg::ADDR_W_DEF;
  localparam int PIX_W       = abb_pkg::PIX_W;
  localparam int POS_W       = abb_pkg::POS_W;
  localparam int DIM_W       = abb_pkg::DIM_W;
  localparam int CFG_IDX_W   = abb_pkg::CFG_IDX_W;
  localparam int CYCLE_LIMIT = 1_500_000;   // clearing sweep plus a slow run, several times over
  localparam int SETTLE      = 12;          // quiet cycles at the end, well past the pipeline depth

  // Register indexes that decode to nothing, then the decoded indexes in order
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{abb_pkg::CFG_FB_WIDTH,
                                                     abb_pkg::CFG_FB_HEIGHT,
                                                     abb_pkg::CFG_DEST_X,
                                                     abb_pkg::CFG_DEST_Y,
                                                     abb_pkg::CFG_DEST_W,
                                                     abb_pkg::CFG_DEST_H};

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              last;
  } blit_result_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [POS_W-1:0]     data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  abb_in_if  in_px_bus ();
  abb_out_if out_px_bus ();
  abb_cfg_if cfg_bus ();

  alpha_blend_blitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px_bus),
    .out_px (out_px_bus),
    .cfg_wr (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: registers, window counters, framebuffer contents
  logic [DIM_W-1:0] fb_width_r  = abb_pkg::RST_FB_WIDTH;
  logic [DIM_W-1:0] fb_height_r = abb_pkg::RST_FB_HEIGHT;
  logic [POS_W-1:0] dest_x_r    = abb_pkg::RST_DEST_X;
  logic [POS_W-1:0] dest_y_r    = abb_pkg::RST_DEST_Y;
  logic [DIM_W-1:0] dest_w_r    = abb_pkg::RST_DEST_W;
  logic [DIM_W-1:0] dest_h_r    = abb_pkg::RST_DEST_H;
  int               col_cnt     = 0;
  int               row_cnt     = 0;
  bit [PIX_W-1:0]   frame_mem [abb_pkg::FB_WORDS_DEF];

  blit_result_t expected_px [$];
  reg_write_t   reg_writes_q [$];

  int err_count   = 0;
  int px_sent     = 0;
  int px_written  = 0;
  int px_checked  = 0;
  int windows_end = 0;
  int reg_count   = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int hold_left   = 0;

  // Zero acts as one, anything above the maximum as the maximum
  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > abb_pkg::MAX_DIM_DEF) return abb_pkg::MAX_DIM_DEF;
    return int'(v);
  endfunction

  // One channel: (a*src + (255-a)*dst) / 255, truncated
  function automatic logic [7:0] mix_chan(logic [7:0] a, logic [7:0] s, logic [7:0] d);
    int t;
    t = (int'(a) * int'(s) + (255 - int'(a)) * int'(d)) / 255;
    return t[7:0];
  endfunction

  // Blend one source word into the shadow framebuffer and step the window counters
  function automatic blit_result_t blend_pixel(logic [PIX_W-1:0] src);
    blit_result_t r;
    int fbw, fbh, win_w, win_h, x0, y0, col, row, lin;
    logic [PIX_W-1:0] dst;
    bit row_end;
    r = '0;
    fbw   = eff_dim(fb_width_r);
    fbh   = eff_dim(fb_height_r);
    win_w = eff_dim(dest_w_r);
    win_h = eff_dim(dest_h_r);
    x0 = $signed(dest_x_r);
    y0 = $signed(dest_y_r);
    if (x0 < 0) x0 = 0;
    if (x0 > fbw - 1) x0 = fbw - 1;
    if (y0 < 0) y0 = 0;
    col = x0 + col_cnt;
    row = y0 + row_cnt;
    if (col <= fbw - 1 && row <= fbh - 1) begin
      lin = row * fbw + col;
      if (lin < abb_pkg::FB_WORDS_DEF) begin
        dst = frame_mem[lin];
        r.pix = {src[31:24], mix_chan(src[31:24], src[23:16], dst[23:16]),
                 mix_chan(src[31:24], src[15:8], dst[15:8]),
                 mix_chan(src[31:24], src[7:0], dst[7:0])};
        frame_mem[lin] = r.pix;
        r.addr = lin[ADDR_W-1:0];
        r.we = 1'b1;
      end
    end
    row_end = col_cnt >= win_w - 1;
    r.last = row_end && row_cnt >= win_h - 1;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = (row_cnt >= win_h - 1) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
    return r;
  endfunction

  // Alpha biased to fully transparent and fully opaque
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [7:0] a;
    case ($urandom_range(3))
      0: a = 8'h00;
      1: a = 8'hFF;
      default: a = 8'($urandom_range(255));
    endcase
    return {a, 24'($urandom)};
  endfunction

  function automatic void report_field(string name, logic [PIX_W-1:0] exp_v,
                                       logic [PIX_W-1:0] act_v);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    err_count++;
  endfunction

  // Scoreboard: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    blit_result_t e;
    if (rst_n === 1'b1 && out_px_bus.valid === 1'b1 && out_px_bus.ready === 1'b1) begin
      if (expected_px.size() == 0) begin
        $display("%0t: result word with nothing expected, addr 0x%0h pixel 0x%0h", $time,
                 out_px_bus.fb_address, out_px_bus.out_pixel);
        err_count++;
      end else begin
        e = expected_px.pop_front();
        px_checked++;
        if (out_px_bus.write_enable !== e.we)
          report_field("write_enable", PIX_W'(e.we), PIX_W'(out_px_bus.write_enable));
        if (out_px_bus.fb_address !== e.addr)
          report_field("fb_address", PIX_W'(e.addr), PIX_W'(out_px_bus.fb_address));
        if (out_px_bus.out_pixel !== e.pix)
          report_field("out_pixel", e.pix, out_px_bus.out_pixel);
        if (out_px_bus.last !== e.last)
          report_field("last", PIX_W'(e.last), PIX_W'(out_px_bus.last));
      end
    end
  end

  // Result-side backpressure in random bursts
  always @(negedge clk) begin
    if (idle_pct == 0) begin
      hold_left = 0;
      out_px_bus.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_px_bus.ready <= 1'b0;
    end else if ($urandom_range(99) < idle_pct) begin
      hold_left = $urandom_range(16);
      out_px_bus.ready <= 1'b0;
    end else begin
      out_px_bus.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, expected_px.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one source word, with an optional gap before it
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    blit_result_t r;
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? $urandom_range(17, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_px_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_px_bus.valid     <= 1'b1;
    in_px_bus.src_pixel <= px;
    do @(posedge clk); while (in_px_bus.ready !== 1'b1);
    r = blend_pixel(px);
    expected_px.push_back(r);
    px_sent++;
    if (r.we) px_written++;
    if (r.last) windows_end++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_px_bus.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
  endtask

  // Apply the queued register writes once the block is idle
  task automatic flush_cfg();
    reg_write_t w;
    drain_results();
    while (reg_writes_q.size() != 0) begin
      w = reg_writes_q.pop_front();
      @(negedge clk);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= w.idx;
      cfg_bus.data  <= w.data;
      do @(posedge clk); while (cfg_bus.ready !== 1'b1);
      reg_count++;
      case (w.idx)
        abb_pkg::CFG_FB_WIDTH:  fb_width_r  = w.data[DIM_W-1:0];
        abb_pkg::CFG_FB_HEIGHT: fb_height_r = w.data[DIM_W-1:0];
        abb_pkg::CFG_DEST_X:    dest_x_r    = w.data;
        abb_pkg::CFG_DEST_Y:    dest_y_r    = w.data;
        abb_pkg::CFG_DEST_W:    dest_w_r    = w.data[DIM_W-1:0];
        abb_pkg::CFG_DEST_H:    dest_h_r    = w.data[DIM_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset register values: every word lands on address 0 and closes the window
  task automatic test_reset_defaults();
    idle_pct = 20;
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0012_3456);
    send_pixel(32'h8000_FF00);
  endtask

  // Zero and oversized dimensions; data bit 10 is ignored on the size registers
  task automatic test_dim_limits();
    reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'd0});
    reg_writes_q.push_back('{abb_pkg::CFG_FB_HEIGHT, 11'd1023});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd5});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'h7FF});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'd0});
    flush_cfg();
    repeat (3) send_pixel(rand_pixel());
    // one-wide window again: the stale column count ends the row
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'd0});
    flush_cfg();
    send_pixel(32'h7F80_40C0);
  endtask

  // Columns past the right edge and rows past the bottom edge are dropped
  task automatic test_clip_edges();
    reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'd4});
    reg_writes_q.push_back('{abb_pkg::CFG_FB_HEIGHT, 11'd3});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'd2});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd2});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'd3});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'd2});
    flush_cfg();
    repeat (6) send_pixel(rand_pixel());
  endtask

  // Origin clamping: left/top at zero, right at width-1, y past the bottom
  task automatic test_origin_clamp();
    reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'd512});
    reg_writes_q.push_back('{abb_pkg::CFG_FB_HEIGHT, 11'd512});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'd1023});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd511});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'd1});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'd1});
    flush_cfg();
    send_pixel(32'hFF00_FFFF);   // top address of the store
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'h400});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'h7FF});
    flush_cfg();
    send_pixel(32'h40FF_0080);
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd512});
    flush_cfg();
    send_pixel(rand_pixel());
    reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'd8});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'd1023});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd2});
    flush_cfg();
    send_pixel(rand_pixel());
  endtask

  // Writes to undecoded indexes change nothing
  task automatic test_spare_index();
    reg_writes_q.push_back('{CFG_SPARE_A, 11'h7FF});
    reg_writes_q.push_back('{CFG_SPARE_B, 11'h000});
    flush_cfg();
    send_pixel(rand_pixel());
  endtask

  // Shrinking the window mid-row: the counters past the new bounds close it
  task automatic test_midwindow_reconfig();
    reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'd8});
    reg_writes_q.push_back('{abb_pkg::CFG_FB_HEIGHT, 11'd8});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'd0});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd0});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'd4});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'd4});
    flush_cfg();
    repeat (3) send_pixel(rand_pixel());
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'd2});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'd1});
    flush_cfg();
    repeat (3) send_pixel(rand_pixel());
  endtask

  // Mostly whole windows over a small framebuffer so words get blended again and again;
  // the rest is random register noise and partial windows
  task automatic test_random_windows();
    int base, fbw, fbh, win_w, win_h, n, pick;
    logic [POS_W-1:0] v;
    base = px_sent;
    while (px_sent - base < 1580) begin
      pick = $urandom_range(3);
      idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
      if ($urandom_range(4) != 0) begin
        fbw   = ($urandom_range(9) == 0) ? 512 : $urandom_range(32, 1);
        fbh   = ($urandom_range(9) == 0) ? 512 : $urandom_range(32, 1);
        win_w = $urandom_range(12, 1);
        win_h = $urandom_range(8, 1);
        reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'(fbw)});
        reg_writes_q.push_back('{abb_pkg::CFG_FB_HEIGHT, 11'(fbh)});
        reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'(int'($urandom_range(fbw + 3)) - 4)});
        reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'(int'($urandom_range(fbh + 3)) - 4)});
        reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'(win_w)});
        reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'(win_h)});
        n = win_w * win_h * $urandom_range(3, 1);
        if (n > 150) n = 150;
      end else begin
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(1) == 1) begin
            case ($urandom_range(9))
              0: v = 11'd0;
              1: v = 11'd1;
              2: v = 11'd511;
              3: v = 11'd512;
              4: v = 11'd513;
              5: v = 11'd1023;
              6: v = 11'h400;
              7: v = 11'h7FF;
              default: v = 11'($urandom_range(2047));
            endcase
            reg_writes_q.push_back('{REG_ORDER[i], v});
          end
        end
        n = $urandom_range(40, 1);
      end
      flush_cfg();
      repeat (n) send_pixel(rand_pixel());
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_pct = 0;
    reg_writes_q.push_back('{abb_pkg::CFG_FB_WIDTH, 11'd16});
    reg_writes_q.push_back('{abb_pkg::CFG_FB_HEIGHT, 11'd16});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_X, 11'd2});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_Y, 11'd3});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_W, 11'd10});
    reg_writes_q.push_back('{abb_pkg::CFG_DEST_H, 11'd6});
    flush_cfg();
    repeat (200) send_pixel(rand_pixel());
  endtask

  initial begin
    rst_n               = 1'b0;
    in_px_bus.valid     = 1'b0;
    in_px_bus.src_pixel = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = abb_pkg::CFG_FB_WIDTH;
    cfg_bus.data        = '0;
    out_px_bus.ready    = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_dim_limits();
    test_clip_edges();
    test_origin_clamp();
    test_spare_index();
    test_midwindow_reconfig();
    test_random_windows();
    test_full_rate();

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d source words (%0d blended into the framebuffer, %0d clipped),",
             px_sent, px_written, px_sent - px_written);
    $display("%0d windows closed, %0d register writes, %0d results checked, %0d errors.",
             windows_end, reg_count, px_checked, err_count);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
